>>> rtl/core/utf8dv_pkg.sv
package utf8dv_pkg;

    localparam int unsigned ScalarWidth = 21;

    // Smallest legal value of an open multi-byte sequence.
    typedef enum logic [1:0] {
        MIN_80    = 2'd0,
        MIN_800   = 2'd1,
        MIN_10000 = 2'd2
    } min_class_t;

    typedef struct packed {
        logic                   error_seen;
        logic [1:0]             bytes_pending;
        logic [ScalarWidth-1:0] partial_value;
        min_class_t             min_class;
    } text_state_t;

    typedef struct packed {
        logic                   still_valid;
        logic                   scalar_ready;
        logic [ScalarWidth-1:0] scalar_value;
        logic                   text_done;
    } result_t;

    localparam logic [7:0] ByteNul     = 8'h00;
    localparam logic [7:0] ByteTab     = 8'h09;
    localparam logic [7:0] ByteLf      = 8'h0A;
    localparam logic [7:0] ByteCr      = 8'h0D;
    localparam logic [7:0] ByteSpace   = 8'h20;
    localparam logic [7:0] ByteDel     = 8'h7F;
    localparam logic [7:0] Lead2Min    = 8'hC2;
    localparam logic [7:0] Lead2Max    = 8'hDF;
    localparam logic [7:0] Lead3Min    = 8'hE0;
    localparam logic [7:0] Lead3Max    = 8'hEF;
    localparam logic [7:0] Lead4Min    = 8'hF0;
    localparam logic [7:0] Lead4Max    = 8'hF4;
    localparam logic [7:0] ContMask    = 8'hC0;
    localparam logic [7:0] ContTag     = 8'h80;

    localparam logic [ScalarWidth-1:0] Min80     = 21'h000080;
    localparam logic [ScalarWidth-1:0] Min800    = 21'h000800;
    localparam logic [ScalarWidth-1:0] Min10000  = 21'h010000;
    localparam logic [ScalarWidth-1:0] MaxScalar = 21'h10FFFF;
    localparam logic [ScalarWidth-1:0] SurrLow   = 21'h00D800;
    localparam logic [ScalarWidth-1:0] SurrHigh  = 21'h00DFFF;
    localparam logic [ScalarWidth-1:0] C1Low     = 21'h000080;
    localparam logic [ScalarWidth-1:0] C1High    = 21'h00009F;

endpackage

>>> rtl/core/utf8dv_decode.sv
module utf8dv_decode
(
    input  utf8dv_pkg::text_state_t state,
    input  logic [7:0]              text_byte,
    input  logic                    end_of_text,
    input  logic                    allow_line_controls,
    output utf8dv_pkg::text_state_t state_next,
    output utf8dv_pkg::result_t     result
);

    logic                                single_ok;
    logic                                scalar_ok;
    logic [utf8dv_pkg::ScalarWidth-1:0]  shifted;
    logic [utf8dv_pkg::ScalarWidth-1:0]  minimum;
    logic                                ready;
    logic [utf8dv_pkg::ScalarWidth-1:0]  value;
    logic                                fail;
    utf8dv_pkg::text_state_t             work;

    always_comb
    begin
        single_ok = 1'b1;
        if (text_byte == utf8dv_pkg::ByteNul || text_byte == utf8dv_pkg::ByteDel)
        begin
            single_ok = 1'b0;
        end
        else if (text_byte < utf8dv_pkg::ByteSpace)
        begin
            single_ok = allow_line_controls &&
                        (text_byte == utf8dv_pkg::ByteTab ||
                         text_byte == utf8dv_pkg::ByteLf ||
                         text_byte == utf8dv_pkg::ByteCr);
        end
    end

    assign shifted = {state.partial_value[utf8dv_pkg::ScalarWidth-7:0], text_byte[5:0]};

    always_comb
    begin
        case (state.min_class)
            utf8dv_pkg::MIN_80:  minimum = utf8dv_pkg::Min80;
            utf8dv_pkg::MIN_800: minimum = utf8dv_pkg::Min800;
            default:             minimum = utf8dv_pkg::Min10000;
        endcase
        scalar_ok = (shifted >= minimum) && (shifted <= utf8dv_pkg::MaxScalar) &&
                    !(shifted >= utf8dv_pkg::SurrLow && shifted <= utf8dv_pkg::SurrHigh) &&
                    !(shifted >= utf8dv_pkg::C1Low && shifted <= utf8dv_pkg::C1High);
    end

    always_comb
    begin
        work  = state;
        ready = 1'b0;
        value = '0;
        fail  = 1'b0;

        if (!state.error_seen)
        begin
            if (state.bytes_pending == 2'd0)
            begin
                if (!text_byte[7])
                begin
                    if (single_ok)
                    begin
                        ready = 1'b1;
                        value = {{(utf8dv_pkg::ScalarWidth-8){1'b0}}, text_byte};
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                else if (text_byte >= utf8dv_pkg::Lead2Min &&
                         text_byte <= utf8dv_pkg::Lead2Max)
                begin
                    work.bytes_pending = 2'd1;
                    work.partial_value = {{(utf8dv_pkg::ScalarWidth-5){1'b0}}, text_byte[4:0]};
                    work.min_class     = utf8dv_pkg::MIN_80;
                end
                else if (text_byte >= utf8dv_pkg::Lead3Min &&
                         text_byte <= utf8dv_pkg::Lead3Max)
                begin
                    work.bytes_pending = 2'd2;
                    work.partial_value = {{(utf8dv_pkg::ScalarWidth-4){1'b0}}, text_byte[3:0]};
                    work.min_class     = utf8dv_pkg::MIN_800;
                end
                else if (text_byte >= utf8dv_pkg::Lead4Min &&
                         text_byte <= utf8dv_pkg::Lead4Max)
                begin
                    work.bytes_pending = 2'd3;
                    work.partial_value = {{(utf8dv_pkg::ScalarWidth-3){1'b0}}, text_byte[2:0]};
                    work.min_class     = utf8dv_pkg::MIN_10000;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            else if ((text_byte & utf8dv_pkg::ContMask) != utf8dv_pkg::ContTag)
            begin
                fail = 1'b1;
            end
            else
            begin
                work.partial_value = shifted;
                work.bytes_pending = state.bytes_pending - 2'd1;
                if (state.bytes_pending == 2'd1)
                begin
                    if (scalar_ok)
                    begin
                        ready              = 1'b1;
                        value              = shifted;
                        work.partial_value = '0;
                        work.min_class     = utf8dv_pkg::MIN_80;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
            end
        end

        // A sequence still open on the last byte fails the whole text.
        if (end_of_text && work.bytes_pending != 2'd0)
        begin
            fail = 1'b1;
        end

        if (fail)
        begin
            work.error_seen    = 1'b1;
            work.bytes_pending = 2'd0;
            work.partial_value = '0;
            work.min_class     = utf8dv_pkg::MIN_80;
        end

        result.still_valid  = !work.error_seen;
        result.scalar_ready = ready;
        result.scalar_value = value;
        result.text_done    = end_of_text;

        if (end_of_text)
        begin
            state_next = '0;
        end
        else
        begin
            state_next = work;
        end
    end

endmodule

>>> rtl/core/utf8_display_text_validator_core.sv
// A word taken into the input register moves on to the result register once that is free.
// Throughput: one byte per cycle unless the receiver stalls; the text state updates with each result.
// The input and result registers each hold a word, so input is taken while a result waits.
// Reset clears the text state, the line-control setting and both valid flags.
module utf8_display_text_validator_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         text_byte,
    input  logic                               end_of_text,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               still_valid,
    output logic                               scalar_ready,
    output logic [utf8dv_pkg::ScalarWidth-1:0] scalar_value,
    output logic                               text_done
);

    logic                    allow_reg;
    logic                    in_valid_reg;
    logic [7:0]              byte_reg;
    logic                    last_reg;
    logic                    out_valid_reg;
    utf8dv_pkg::result_t     result_reg;
    utf8dv_pkg::result_t     result_next;
    utf8dv_pkg::text_state_t state_reg;
    utf8dv_pkg::text_state_t state_next;
    logic                    out_advance;
    logic                    in_advance;

    // The decode stage moves its word on when the result register is free.
    assign out_advance = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall    = in_valid_reg && !out_advance;
    assign in_advance  = in_valid && !in_stall;

    utf8dv_decode u_decode
    (
        .state               (state_reg),
        .text_byte           (byte_reg),
        .end_of_text         (last_reg),
        .allow_line_controls (allow_reg),
        .state_next          (state_next),
        .result              (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_reg     <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                allow_reg <= cfg_wdata;
            end
            if (in_advance)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (out_advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (out_advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance)
        begin
            byte_reg <= text_byte;
            last_reg <= end_of_text;
        end
        if (out_advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign still_valid  = result_reg.still_valid;
    assign scalar_ready = result_reg.scalar_ready;
    assign scalar_value = result_reg.scalar_value;
    assign text_done    = result_reg.text_done;

endmodule

>>> test/utf8_text_verdict_checker.sv
`timescale 1ns / 100ps

module utf8_text_verdict_checker
    import utf8dv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [7:0]             text_byte,
    input  logic                   end_of_text,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic                   still_valid,
    input  logic                   scalar_ready,
    input  logic [ScalarWidth-1:0] scalar_value,
    input  logic                   text_done,
    output int                     fail_count,
    output int                     verdicts_due
);

    localparam int MaxPrinted = 100;

    text_state_t text_st;
    logic        line_controls_on;
    result_t     verdicts_pending[$];
    int          mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string msg);
        if (mismatches < MaxPrinted)
        begin
            $display("ERROR %0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    // A broken rule drops any open sequence and holds the text as failed.
    function automatic void flag_error();
        text_st = '0;
        text_st.error_seen = 1'b1;
    endfunction

    function automatic logic plain_byte_ok(input logic [7:0] b);
        if (b == ByteNul || b == ByteDel)
        begin
            return 1'b0;
        end
        if (b < ByteSpace)
        begin
            return line_controls_on && (b == ByteTab || b == ByteLf || b == ByteCr);
        end
        return 1'b1;
    endfunction

    function automatic logic scalar_in_range(input logic [ScalarWidth-1:0] v,
                                             input min_class_t cls);
        logic [ScalarWidth-1:0] lowest;
        case (cls)
            MIN_80:  lowest = Min80;
            MIN_800: lowest = Min800;
            default: lowest = Min10000;
        endcase
        if (v < lowest || v > MaxScalar)
        begin
            return 1'b0;
        end
        if (v >= SurrLow && v <= SurrHigh)
        begin
            return 1'b0;
        end
        if (v >= C1Low && v <= C1High)
        begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic result_t decode_text_byte(input logic [7:0] b, input logic last);
        result_t r;
        r = '0;
        if (!text_st.error_seen)
        begin
            if (text_st.bytes_pending == 2'd0)
            begin
                if (b[7] == 1'b0)
                begin
                    if (plain_byte_ok(b))
                    begin
                        r.scalar_ready = 1'b1;
                        r.scalar_value = ScalarWidth'(b);
                    end
                    else
                    begin
                        flag_error();
                    end
                end
                else if (b >= Lead2Min && b <= Lead2Max)
                begin
                    text_st.bytes_pending = 2'd1;
                    text_st.partial_value = ScalarWidth'(b[4:0]);
                    text_st.min_class = MIN_80;
                end
                else if (b >= Lead3Min && b <= Lead3Max)
                begin
                    text_st.bytes_pending = 2'd2;
                    text_st.partial_value = ScalarWidth'(b[3:0]);
                    text_st.min_class = MIN_800;
                end
                else if (b >= Lead4Min && b <= Lead4Max)
                begin
                    text_st.bytes_pending = 2'd3;
                    text_st.partial_value = ScalarWidth'(b[2:0]);
                    text_st.min_class = MIN_10000;
                end
                else
                begin
                    flag_error();
                end
            end
            else if ((b & ContMask) != ContTag)
            begin
                flag_error();
            end
            else
            begin
                text_st.partial_value = {text_st.partial_value[ScalarWidth-7:0], b[5:0]};
                text_st.bytes_pending = text_st.bytes_pending - 2'd1;
                if (text_st.bytes_pending == 2'd0)
                begin
                    if (scalar_in_range(text_st.partial_value, text_st.min_class))
                    begin
                        r.scalar_ready = 1'b1;
                        r.scalar_value = text_st.partial_value;
                        text_st.partial_value = '0;
                        text_st.min_class = MIN_80;
                    end
                    else
                    begin
                        flag_error();
                    end
                end
            end
        end
        // A sequence still open on the last byte fails the whole text.
        if (last && text_st.bytes_pending != 2'd0)
        begin
            flag_error();
        end
        r.still_valid = !text_st.error_seen;
        r.text_done = last;
        if (last)
        begin
            text_st = '0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            text_st = '0;
            line_controls_on = 1'b0;
            verdicts_pending.delete();
            verdicts_due <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                line_controls_on = cfg_wdata;
            end
            if (in_valid && !in_stall)
            begin
                verdicts_pending.push_back(decode_text_byte(text_byte, end_of_text));
            end
            if (out_valid && !out_stall)
            begin
                if (verdicts_pending.size() == 0)
                begin
                    report_mismatch("result word arrived with nothing expected");
                end
                else
                begin
                    want = verdicts_pending.pop_front();
                    if (still_valid !== want.still_valid)
                    begin
                        report_mismatch($sformatf("still_valid %b, expected %b",
                                                  still_valid, want.still_valid));
                    end
                    if (scalar_ready !== want.scalar_ready)
                    begin
                        report_mismatch($sformatf("scalar_ready %b, expected %b",
                                                  scalar_ready, want.scalar_ready));
                    end
                    if (scalar_value !== want.scalar_value)
                    begin
                        report_mismatch($sformatf("scalar_value %h, expected %h",
                                                  scalar_value, want.scalar_value));
                    end
                    if (text_done !== want.text_done)
                    begin
                        report_mismatch($sformatf("text_done %b, expected %b",
                                                  text_done, want.text_done));
                    end
                end
            end
            verdicts_due <= verdicts_pending.size();
        end
    end

endmodule

>>> test/tb_utf8_display_text_validator_core.sv
`timescale 1ns / 100ps

module tb_utf8_display_text_validator_core;
    import utf8dv_pkg::*;

    localparam int QuietLimit = 2000;
    localparam int HoldCycles = 80;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic                   cfg_wdata = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [7:0]             text_byte = 8'h00;
    logic                   end_of_text = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   still_valid;
    logic                   scalar_ready;
    logic [ScalarWidth-1:0] scalar_value;
    logic                   text_done;

    int         fail_count;
    int         verdicts_due;
    int         quiet_cycles = 0;
    bit         sender_idles = 1'b1;
    bit         receiver_idles = 1'b1;
    logic       hold_req = 1'b0;
    logic [7:0] text_bytes[$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    utf8_display_text_validator_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .still_valid  (still_valid),
        .scalar_ready (scalar_ready),
        .scalar_value (scalar_value),
        .text_done    (text_done)
    );

    utf8_text_verdict_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .still_valid  (still_valid),
        .scalar_ready (scalar_ready),
        .scalar_value (scalar_value),
        .text_done    (text_done),
        .fail_count   (fail_count),
        .verdicts_due (verdicts_due)
    );

    // The run is abandoned if no word moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QuietLimit)
        begin
            $display("utf8_display_text_validator_core: mismatch");
            $finish;
        end
    end

    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req <= 1'b0;
                out_stall <= 1'b1;
                repeat (HoldCycles) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (receiver_idles && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic last);
        if (sender_idles && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        text_byte <= b;
        end_of_text <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_bytes.size(); i++)
        begin
            send_word(text_bytes[i], i == text_bytes.size() - 1);
        end
    endtask

    // Stop offering bytes and wait for every verdict before touching the setting.
    task automatic write_line_controls(input logic setting);
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdicts_due != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= setting;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Encodes v in n bytes whether or not n is the shortest form.
    function automatic void add_encoded(input logic [ScalarWidth-1:0] v, input int n);
        if (n == 2)
        begin
            text_bytes.push_back({3'b110, v[10:6]});
        end
        else if (n == 3)
        begin
            text_bytes.push_back({4'b1110, v[15:12]});
            text_bytes.push_back({2'b10, v[11:6]});
        end
        else
        begin
            text_bytes.push_back({5'b11110, v[20:18]});
            text_bytes.push_back({2'b10, v[17:12]});
            text_bytes.push_back({2'b10, v[11:6]});
        end
        text_bytes.push_back({2'b10, v[5:0]});
    endfunction

    function automatic void add_random_piece();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        n = $urandom_range(2, 4);
        if (pick < 25)
        begin
            text_bytes.push_back(8'($urandom_range(32'h20, 32'h7E)));
        end
        else if (pick < 31)
        begin
            case ($urandom_range(0, 4))
                0: text_bytes.push_back(ByteTab);
                1: text_bytes.push_back(ByteLf);
                2: text_bytes.push_back(ByteCr);
                3: text_bytes.push_back(ByteDel);
                default: text_bytes.push_back(8'($urandom_range(0, 31)));
            endcase
        end
        else if (pick < 48)
        begin
            add_encoded(21'($urandom_range(32'h80, 32'h7FF)), 2);
        end
        else if (pick < 66)
        begin
            add_encoded(21'($urandom_range(32'h800, 32'hFFFF)), 3);
        end
        else if (pick < 82)
        begin
            add_encoded(21'($urandom_range(32'h10000, 32'h10FFFF)), 4);
        end
        else if (pick < 85)
        begin
            add_encoded(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
        end
        else if (pick < 89)
        begin
            // Overlong: a value that fits in a shorter form.
            case (n)
                2: add_encoded(21'($urandom_range(0, 32'h7F)), 2);
                3: add_encoded(21'($urandom_range(0, 32'h7FF)), 3);
                default: add_encoded(21'($urandom_range(0, 32'hFFFF)), 4);
            endcase
        end
        else if (pick < 94)
        begin
            // A sequence cut short, so the next byte or the text end breaks it.
            add_encoded(21'($urandom()), n);
            repeat ($urandom_range(1, n - 1)) void'(text_bytes.pop_back());
        end
        else
        begin
            text_bytes.push_back(8'($urandom()));
        end
    endfunction

    task automatic send_random_texts(input int budget);
        int sent;
        sent = 0;
        while (sent < budget)
        begin
            text_bytes.delete();
            repeat ($urandom_range(1, 5)) add_random_piece();
            send_text();
            sent += text_bytes.size();
        end
    endtask

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Line controls are off after reset.
        text_bytes = '{8'h20, 8'hDF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_text();
        text_bytes = '{8'h7E, 8'h7F};
        send_text();
        text_bytes = '{8'h00, 8'h41};
        send_text();
        text_bytes = '{8'h09};
        send_text();
        text_bytes = '{8'hC2, 8'h80};
        send_text();
        text_bytes = '{8'hC1};
        send_text();
        text_bytes = '{8'hE0, 8'h9F, 8'hBF};
        send_text();
        text_bytes = '{8'hED, 8'hA0, 8'h80};
        send_text();
        text_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_text();
        text_bytes = '{8'hE2, 8'h82};
        send_text();
        text_bytes = '{8'hC3, 8'h41};
        send_text();

        write_line_controls(1'b1);
        text_bytes = '{8'h09, 8'h0A, 8'h0D};
        send_text();
        send_random_texts(450);

        write_line_controls(1'b0);
        hold_req <= 1'b1;
        send_random_texts(400);

        write_line_controls(1'b1);
        send_random_texts(400);

        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        write_line_controls(1'b0);
        send_random_texts(200);

        in_valid <= 1'b0;
        @(posedge clk);
        while (verdicts_due != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("utf8_display_text_validator_core: match");
        end
        else
        begin
            $display("utf8_display_text_validator_core: mismatch");
        end
        $finish;
    end

endmodule
